@@ rtl/core/fcce_pkg.sv @@
// Shared types, command codes and decode helpers of the floppy controller command engine.
`timescale 1ns / 1ps
`default_nettype none
package fcce_pkg;

  localparam int unsigned SECTOR_BYTES_DEF = 512;

  localparam logic [2:0] OFF_DOR  = 3'd2;
  localparam logic [2:0] OFF_MSR  = 3'd4;
  localparam logic [2:0] OFF_DATA = 3'd5;
  localparam logic [2:0] OFF_DIR  = 3'd7;

  localparam logic [7:0] OPC_SPECIFY     = 8'h03;
  localparam logic [7:0] OPC_SENSE_DRIVE = 8'h04;
  localparam logic [4:0] OPC_READ        = 5'h06;
  localparam logic [7:0] OPC_RECAL       = 8'h07;
  localparam logic [7:0] OPC_SENSE_INT   = 8'h08;
  localparam logic [4:0] OPC_READ_ID     = 5'h0a;
  localparam logic [7:0] OPC_SEEK        = 8'h0F;

  localparam logic CFG_DRIVE_MASK = 1'b0;
  localparam logic CFG_DMA_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE, OP_SPECIFY, OP_SENSE_DRIVE, OP_READ, OP_RECAL, OP_SENSE_INT,
    OP_READ_ID, OP_SEEK
  } op_e;

  typedef enum logic {ST_IDLE, ST_ADVANCE} ctl_state_e;

  typedef struct packed {
    logic acc;
    logic step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic launch_read;
    logic loop_last;
  } dp_status_t;

  function automatic op_e op_decode(input logic [7:0] op);
    op_e k;
    k = OP_NONE;
    if (op == OPC_SPECIFY) k = OP_SPECIFY;
    else if (op == OPC_SENSE_DRIVE) k = OP_SENSE_DRIVE;
    else if (op[4:0] == OPC_READ) k = OP_READ;
    else if (op == OPC_RECAL) k = OP_RECAL;
    else if (op == OPC_SENSE_INT) k = OP_SENSE_INT;
    else if (op[4:0] == OPC_READ_ID) k = OP_READ_ID;
    else if (op == OPC_SEEK) k = OP_SEEK;
    return k;
  endfunction

  function automatic logic [3:0] op_length(input op_e k);
    logic [3:0] n;
    unique case (k)
      OP_SPECIFY:     n = 4'd3;
      OP_SENSE_DRIVE: n = 4'd2;
      OP_READ:        n = 4'd9;
      OP_RECAL:       n = 4'd2;
      OP_SENSE_INT:   n = 4'd1;
      OP_READ_ID:     n = 4'd2;
      OP_SEEK:        n = 4'd3;
      default:        n = 4'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fcce_ctrl.sv @@
// Sequencer of the command engine: accepts transactions and walks the read sector loop.
`timescale 1ns / 1ps
`default_nettype none
module fcce_ctrl
  import fcce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       full_i,
  input  wire dp_status_t status_i,
  output logic            in_ready_o,
  output ctl_cmd_t        cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !full_i;
        cmd_o.acc = in_valid_i && !full_i;
        if (cmd_o.acc && status_i.launch_read) state_d = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        if (status_i.loop_last) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/fcce_datapath.sv @@
// Register state, command execution and sector advance unit of the command engine.
`timescale 1ns / 1ps
`default_nettype none
module fcce_datapath
  import fcce_pkg::*;
#(
  parameter int unsigned SectorBytes = SECTOR_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctl_cmd_t   cmd_i,
  input  wire logic       cmd_bit_i,
  input  wire logic [2:0] offset_i,
  input  wire logic [7:0] data_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output dp_status_t      status_o,
  output logic [7:0]      res_data_o,
  output logic            res_irq_o
);

  localparam int unsigned Shift = $clog2(SectorBytes);
  localparam int unsigned CntW  = 17 - Shift;

  logic [3:0]  mask_q;
  logic [15:0] dma_q;
  logic [7:0]  dor_q, dor_d, st0_q, st0_d;
  logic [3:0]  cl_q, cl_d, cp_q, cp_d, rcf_q, rcf_d;
  logic [2:0]  rl_q, rl_d, rp_q, rp_d;
  logic [7:0]  cb_q [9];
  logic [7:0]  cb_d [9];
  logic [7:0]  rb_q [7];
  logic [7:0]  rb_d [7];
  logic [7:0]  dcyl_q [4];
  logic [7:0]  dcyl_d [4];
  logic [7:0]  lp_rec_q, lp_rec_d, lp_cyl_q, lp_cyl_d;
  logic        lp_head_q, lp_head_d, lp_fail_q, lp_fail_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 4'hF;
      dma_q  <= 16'd511;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DRIVE_MASK) mask_q <= cfg_data_i[3:0];
      else dma_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dor_q <= '0; st0_q <= '0; cl_q <= '0; cp_q <= '0; rcf_q <= '0;
      rl_q <= '0; rp_q <= '0; cnt_q <= '0;
      for (int i = 0; i < 4; i++) dcyl_q[i] <= '0;
    end else begin
      dor_q <= dor_d; st0_q <= st0_d; cl_q <= cl_d; cp_q <= cp_d; rcf_q <= rcf_d;
      rl_q <= rl_d; rp_q <= rp_d; cnt_q <= cnt_d;
      for (int i = 0; i < 4; i++) dcyl_q[i] <= dcyl_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) cb_q[i] <= cb_d[i];
    for (int i = 0; i < 7; i++) rb_q[i] <= rb_d[i];
    lp_rec_q <= lp_rec_d; lp_cyl_q <= lp_cyl_d;
    lp_head_q <= lp_head_d; lp_fail_q <= lp_fail_d;
  end

  logic [7:0]  rd;
  logic        irq;
  logic [3:0]  nl, np;
  logic [1:0]  unit, su;
  logic        head, present;
  logic [2:0]  rp_n;
  logic [7:0]  s, rec_n;
  logic [15:0] sectors;
  op_e         kind;

  always_comb begin
    dor_d = dor_q; st0_d = st0_q; cl_d = cl_q; cp_d = cp_q; rcf_d = rcf_q;
    rl_d = rl_q; rp_d = rp_q; cnt_d = cnt_q;
    for (int i = 0; i < 9; i++) cb_d[i] = cb_q[i];
    for (int i = 0; i < 7; i++) rb_d[i] = rb_q[i];
    for (int i = 0; i < 4; i++) dcyl_d[i] = dcyl_q[i];
    lp_rec_d = lp_rec_q; lp_cyl_d = lp_cyl_q; lp_head_d = lp_head_q; lp_fail_d = lp_fail_q;
    rd = 8'h00; irq = 1'b0; status_o = '0;
    nl = cl_q; np = cp_q; unit = '0; su = '0; head = 1'b0; present = 1'b0;
    rp_n = '0; s = '0; rec_n = '0; kind = OP_NONE;
    sectors = dma_q >> Shift;

    if (cmd_i.acc) begin
      if (!cmd_bit_i) begin
        case (offset_i)
          OFF_MSR: rd = (rl_q != 3'd0) ? 8'hD0 : 8'h80;
          OFF_DATA: begin
            if (rl_q != 3'd0) begin
              rd = rb_q[(rp_q == 3'd7) ? 3'd0 : rp_q];
              rp_n = 3'(rp_q + 3'd1);
              rp_d = rp_n;
              if (rp_n == rl_q) rl_d = 3'd0;
            end else begin
              rd = 8'hFF;
            end
          end
          OFF_DIR: rd = 8'h00;
          default: rd = 8'hFF;
        endcase
      end else if (offset_i == OFF_DOR) begin
        if (!dor_q[2] && data_i[2]) begin
          irq = data_i[3];
          rcf_d = 4'hF;
        end
        dor_d = data_i;
      end else if (offset_i == OFF_DATA) begin
        if (cl_q == 4'd0) begin
          cb_d[0] = data_i;
          nl = op_length(op_decode(data_i));
          if (nl != 4'd0) np = 4'd1;
        end else begin
          if (cp_q < 4'd9) cb_d[cp_q] = data_i;
          np = 4'(cp_q + 4'd1);
        end
        cl_d = nl;
        cp_d = np;
        if (nl != 4'd0 && np == nl) begin
          kind = op_decode(cb_d[0]);
          unit = cb_d[1][1:0];
          head = cb_d[1][2];
          present = mask_q[unit];
          unique case (kind)
            OP_SENSE_DRIVE: begin
              rb_d[0] = (dcyl_q[unit] == 8'd0) ? 8'h30 : 8'h20;
              rl_d = 3'd1;
            end
            OP_READ: begin
              status_o.launch_read = 1'b1;
              lp_rec_d = cb_d[4];
              lp_cyl_d = cb_d[2];
              lp_head_d = head;
              lp_fail_d = !present;
              cnt_d = present ? CntW'(sectors) + CntW'(1) : '0;
            end
            OP_RECAL, OP_SEEK: begin
              st0_d = {6'd0, unit} | (present ? 8'h20 : 8'h50);
              if (present) dcyl_d[unit] = (kind == OP_RECAL) ? 8'd0 : cb_d[2];
              irq = dor_q[3];
            end
            OP_SENSE_INT: begin
              s = st0_q;
              if (rcf_q != 4'd0) begin
                if (rcf_q[0]) su = 2'd0;
                else if (rcf_q[1]) su = 2'd1;
                else if (rcf_q[2]) su = 2'd2;
                else su = 2'd3;
                rcf_d[su] = 1'b0;
                s = {6'b110000, su};
              end
              rb_d[0] = s;
              rb_d[1] = dcyl_q[s[1:0]];
              rl_d = 3'd2;
              st0_d = 8'd0;
            end
            OP_READ_ID: begin
              s = {5'd0, head, unit};
              st0_d = s;
              rb_d[0] = s; rb_d[1] = 8'd0; rb_d[2] = 8'd0; rb_d[3] = dcyl_q[unit];
              rb_d[4] = {7'd0, head}; rb_d[5] = 8'd1; rb_d[6] = 8'd2;
              rl_d = 3'd7;
              irq = dor_q[3];
            end
            OP_SPECIFY, OP_NONE: irq = 1'b0;
          endcase
          cl_d = 4'd0;
          rp_d = 3'd0;
        end
      end
    end

    // one sector advance per cycle
    if (cmd_i.step) begin
      rec_n = 8'(lp_rec_q + 8'd1);
      if (rec_n > cb_q[6]) begin
        lp_rec_d = 8'd1;
        lp_head_d = !lp_head_q;
        if (lp_head_q) lp_cyl_d = 8'(lp_cyl_q + 8'd1);
      end else begin
        lp_rec_d = rec_n;
      end
      cnt_d = CntW'(cnt_q - CntW'(1));
    end

    if (cmd_i.finish) begin
      s = {1'b0, lp_fail_q, 3'd0, lp_head_q, cb_q[1][1:0]};
      st0_d = s;
      rb_d[0] = s; rb_d[1] = 8'd0; rb_d[2] = 8'd0; rb_d[3] = lp_cyl_q;
      rb_d[4] = {7'd0, lp_head_q}; rb_d[5] = lp_rec_q; rb_d[6] = cb_q[5];
      rl_d = 3'd7;
    end

    status_o.loop_last = (cnt_q == '0);
    res_data_o = cmd_i.finish ? 8'h00 : rd;
    res_irq_o  = cmd_i.finish ? dor_q[3] : irq;
  end

endmodule
`default_nettype wire

@@ rtl/core/floppy_controller_command_engine.sv @@
// Top level of the 765-style floppy controller command engine with its result queue.
//
// Usage: each input transaction is one bus access (cmd_i: 0 read, 1 write;
// reg_offset_i; write_data_i). Every access yields exactly one result
// transaction (read_data_o, irq_pulse_o) on the output channel, in order.
// Both channels use valid/ready; a transaction moves when both are high.
// Most accesses finish in the accept cycle and their result is visible
// in the next cycle. The data write that completes a read command runs
// the sector advance loop, one sector per cycle, and advances
// floor(count / SectorBytes) + 1 sectors (none when the drive is absent).
// SectorBytes must be a power of two.
// Throughput: one access per cycle outside read commands while the
// result queue is not full; the advance loop blocks new accesses while it runs.
// A two-entry result queue decouples the sides: input is still accepted
// while one result waits on a stalled receiver; with two waiting, hold
// in_ready_o low until out_ready_i drains one.
// Reset clears all control state, the drive cylinders and the queue; the
// configuration registers return to mask 15 and count 511. Write config
// through cfg_we_i only while idle.
`timescale 1ns / 1ps
`default_nettype none
module floppy_controller_command_engine
  import fcce_pkg::*;
#(
  parameter int unsigned SectorBytes = SECTOR_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [2:0]  reg_offset_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             irq_pulse_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic [7:0] res_data;
  logic       res_irq;

  // result queue: two entries, pointer based
  logic [8:0] q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop, full;

  assign full = (cnt_q == 2'd2);
  assign push = (cmd.acc && !status.launch_read) || cmd.finish;
  assign pop  = out_valid_o && out_ready_i;

  fcce_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .full_i(full), .status_i(status),
    .in_ready_o, .cmd_o(cmd)
  );

  fcce_datapath #(.SectorBytes(SectorBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_bit_i(cmd_i), .offset_i(reg_offset_i),
    .data_i(write_data_i), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .status_o(status), .res_data_o(res_data), .res_irq_o(res_irq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= {res_irq, res_data};
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign read_data_o = q_mem[rp_q][7:0];
  assign irq_pulse_o = q_mem[rp_q][8];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!full || pop)) else $error("result queue overflow");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step || cmd.finish) |-> !in_ready_o) else $error("accept during sector loop");
  a_one_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.acc && cmd.finish)) else $error("accept and finish in one cycle");

endmodule
`default_nettype wire

@@ tb/sv/tb_floppy_controller_command_engine.sv @@
// Self-checking testbench of the floppy controller command engine.
`timescale 1ns / 1ps
module tb_floppy_controller_command_engine;
  import fcce_pkg::*;

  localparam int WATCHDOG_CYCLES = 6000;  // cycles without any transaction
  localparam int DRAIN_CYCLES    = 140;   // longest read advance loop plus margin
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the result queue

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [2:0]  reg_offset_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        irq_pulse_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  floppy_controller_command_engine DUT (.*);

  always #6 clk_i = ~clk_i;

  // One result transaction: the byte read back and the interrupt pulse.
  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } bus_reply_t;

  bus_reply_t pending_replies[$];
  int         fail_count = 0;

  // Idle percentages of each side, and the long receiver hold-off request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_req = 1'b0;

  // Shadow of the controller state, kept in step with every accepted access.
  logic [3:0]  sh_mask;
  logic [15:0] sh_dma_count;
  logic [7:0]  sh_dor;
  logic [7:0]  sh_cmd_buf [9];
  logic [3:0]  sh_cmd_len;
  logic [3:0]  sh_cmd_pos;
  logic [7:0]  sh_res_buf [7];
  logic [2:0]  sh_res_len;
  logic [2:0]  sh_res_pos;
  logic [7:0]  sh_st0;
  logic [7:0]  sh_cyl [4];
  logic [3:0]  sh_ready_chg;

  task automatic report(input string what, input logic [7:0] exp_v, input logic [7:0] got_v);
    $display("%0t ns: mismatch on %s: expected %02h, got %02h", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  function automatic logic [3:0] command_length_of(input logic [7:0] op);
    if (op == OPC_SPECIFY) return 4'd3;
    if (op == OPC_SENSE_DRIVE) return 4'd2;
    if (op[4:0] == OPC_READ) return 4'd9;
    if (op == OPC_RECAL) return 4'd2;
    if (op == OPC_SENSE_INT) return 4'd1;
    if (op[4:0] == OPC_READ_ID) return 4'd2;
    if (op == OPC_SEEK) return 4'd3;
    return 4'd0;
  endfunction

  function automatic void load_seven(input logic [7:0] st0, input logic [7:0] cyl,
                                     input logic [7:0] hd, input logic [7:0] rec,
                                     input logic [7:0] num);
    sh_res_buf[0] = st0;
    sh_res_buf[1] = 8'h00;
    sh_res_buf[2] = 8'h00;
    sh_res_buf[3] = cyl;
    sh_res_buf[4] = hd;
    sh_res_buf[5] = rec;
    sh_res_buf[6] = num;
    sh_res_len = 3'd7;
  endfunction

  // Run a complete command; return the interrupt pulse it raises.
  function automatic logic run_command();
    logic [7:0]  op;
    logic [1:0]  unit;
    logic        hd;
    logic        irq;
    logic [7:0]  cyl;
    logic [7:0]  rec;
    logic [7:0]  eot;
    logic        failed;
    int unsigned sectors;
    int unsigned u;
    op = sh_cmd_buf[0];
    unit = sh_cmd_buf[1][1:0];
    hd = sh_cmd_buf[1][2];
    irq = sh_dor[3];
    if (op == OPC_SENSE_DRIVE) begin
      sh_res_buf[0] = 8'h20 | ((sh_cyl[unit] == 8'h00) ? 8'h10 : 8'h00);
      sh_res_len = 3'd1;
      irq = 1'b0;
    end else if (op[4:0] == OPC_READ) begin
      cyl = sh_cmd_buf[2];
      rec = sh_cmd_buf[4];
      eot = sh_cmd_buf[6];
      failed = !sh_mask[unit];
      if (!failed) begin
        // whole sectors in the byte count, plus one
        sectors = (int'(sh_dma_count) + SECTOR_BYTES_DEF) / SECTOR_BYTES_DEF;
        for (int i = 0; i < sectors; i++) begin
          rec = rec + 8'd1;
          if (rec > eot) begin
            rec = 8'd1;
            if (!hd) hd = 1'b1;
            else begin
              hd = 1'b0;
              cyl = cyl + 8'd1;
            end
          end
        end
      end
      sh_st0 = {1'b0, failed, 3'b000, hd, unit};
      load_seven(sh_st0, cyl, {7'd0, hd}, rec, sh_cmd_buf[5]);
    end else if (op == OPC_RECAL || op == OPC_SEEK) begin
      if (!sh_mask[unit]) sh_st0 = 8'h50 | {6'd0, unit};
      else begin
        sh_cyl[unit] = (op == OPC_RECAL) ? 8'h00 : sh_cmd_buf[2];
        sh_st0 = 8'h20 | {6'd0, unit};
      end
    end else if (op == OPC_SENSE_INT) begin
      if (sh_ready_chg != 4'd0) begin
        // report the lowest drive with a pending ready change
        u = 0;
        while (u < 3 && !sh_ready_chg[u[1:0]]) u++;
        sh_ready_chg[u[1:0]] = 1'b0;
        sh_st0 = 8'hC0 | u[7:0];
      end
      sh_res_buf[0] = sh_st0;
      sh_res_buf[1] = sh_cyl[sh_st0[1:0]];
      sh_res_len = 3'd2;
      sh_st0 = 8'h00;
      irq = 1'b0;
    end else if (op[4:0] == OPC_READ_ID) begin
      sh_st0 = {5'd0, hd, unit};
      load_seven(sh_st0, sh_cyl[unit], {7'd0, hd}, 8'd1, 8'd2);
    end else begin
      irq = 1'b0;
    end
    sh_cmd_len = 4'd0;
    sh_res_pos = 3'd0;
    return irq;
  endfunction

  // Predict the reply to one accepted bus access and advance the shadow state.
  function automatic bus_reply_t predict_access(input logic wr, input logic [2:0] off,
                                                input logic [7:0] data);
    bus_reply_t r;
    r = '0;
    if (!wr) begin
      if (off == OFF_MSR) r.rd = (sh_res_len != 0) ? 8'hD0 : 8'h80;
      else if (off == OFF_DATA) begin
        if (sh_res_len != 0) begin
          r.rd = sh_res_buf[(sh_res_pos == 3'd7) ? 3'd0 : sh_res_pos];
          sh_res_pos = sh_res_pos + 3'd1;
          if (sh_res_pos == sh_res_len) sh_res_len = 3'd0;
        end else r.rd = 8'hFF;
      end else if (off == OFF_DIR) r.rd = 8'h00;
      else r.rd = 8'hFF;
    end else if (off == OFF_DOR) begin
      if (!sh_dor[2] && data[2]) begin
        r.irq = data[3];
        sh_ready_chg = 4'hF;
      end
      sh_dor = data;
    end else if (off == OFF_DATA) begin
      if (sh_cmd_len == 0) begin
        sh_cmd_buf[0] = data;
        sh_cmd_len = command_length_of(data);
        if (sh_cmd_len != 0) sh_cmd_pos = 4'd1;
      end else begin
        if (sh_cmd_pos < 9) sh_cmd_buf[sh_cmd_pos] = data;
        sh_cmd_pos = sh_cmd_pos + 4'd1;
      end
      if (sh_cmd_len != 0 && sh_cmd_pos == sh_cmd_len) r.irq = run_command();
    end
    return r;
  endfunction

  // Offer one access; hold it until accepted, then queue its reply.
  // With check set, the typed reply replaces the predicted one.
  task automatic offer_access(input logic wr, input logic [2:0] off, input logic [7:0] data,
                              input bit check = 1'b0, input logic [7:0] exp_rd = '0,
                              input logic exp_irq = 1'b0);
    bus_reply_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= wr;
    reg_offset_i <= off;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_access(wr, off, data);
    if (check) pending_replies.push_back({exp_rd, exp_irq});
    else pending_replies.push_back(r);
  endtask

  task automatic write_config(input logic idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_DRIVE_MASK) sh_mask = value[3:0];
    else sh_dma_count = value;
  endtask

  // Wait until every reply is in and any silent advance loop has ended.
  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One random unit of traffic: mostly a well-formed command followed by
  // reading its results, sometimes a motor toggle, a broken command or plain noise.
  task automatic random_traffic(inout int count);
    int unsigned pick;
    int unsigned nbytes;
    logic [7:0]  op;
    pick = $urandom_range(99);
    if (pick < 12) begin
      offer_access(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom));
      count++;
      return;
    end
    if (pick < 20) begin
      // toggle the motor-enable bit to exercise ready-change handling
      offer_access(1'b1, OFF_DOR, {8'($urandom)} & 8'hFB);
      offer_access(1'b1, OFF_DOR, 8'($urandom) | 8'h04);
      count += 2;
      return;
    end
    case ($urandom_range(6))
      0: op = OPC_SPECIFY;
      1: op = OPC_SENSE_DRIVE;
      2: op = {3'($urandom), OPC_READ};
      3: op = OPC_RECAL;
      4: op = OPC_SENSE_INT;
      5: op = {3'($urandom), OPC_READ_ID};
      default: op = OPC_SEEK;
    endcase
    nbytes = {28'd0, command_length_of(op)};
    if (pick < 26 && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);  // truncated
    offer_access(1'b1, OFF_DATA, op);
    for (int i = 1; i < nbytes; i++) offer_access(1'b1, OFF_DATA, 8'($urandom));
    count += nbytes;
    if ($urandom_range(3) == 0) begin
      offer_access(1'b0, OFF_MSR, 8'($urandom));
      count++;
    end
    repeat ($urandom_range(0, 8)) begin
      offer_access(1'b0, OFF_DATA, 8'($urandom));
      count++;
    end
  endtask

  // Directed table: access, and the reply where it is obvious.
  typedef struct {
    logic       wr;
    logic [2:0] off;
    logic [7:0] data;
    bit         check;
    logic [7:0] rd;
    logic       irq;
  } access_row_t;

  access_row_t directed_rows[] = '{
    '{1'b0, OFF_MSR,  8'h00, 1, 8'h80, 1'b0},  // idle status after reset
    '{1'b0, OFF_DATA, 8'h00, 1, 8'hFF, 1'b0},  // data read with nothing pending
    '{1'b0, OFF_DIR,  8'hFF, 1, 8'h00, 1'b0},
    '{1'b0, 3'd0,     8'h00, 1, 8'hFF, 1'b0},  // unmapped read offset
    '{1'b1, 3'd6,     8'hFF, 1, 8'h00, 1'b0},  // unmapped write is dropped
    '{1'b1, OFF_DOR,  8'h0C, 1, 8'h00, 1'b1},  // motor enable rises with irq enabled
    '{1'b1, OFF_DATA, 8'hFF, 1, 8'h00, 1'b0},  // unknown opcode is dropped
    '{1'b1, OFF_DATA, OPC_SENSE_INT, 1, 8'h00, 1'b0},
    '{1'b0, OFF_MSR,  8'h00, 1, 8'hD0, 1'b0},
    '{1'b0, OFF_DATA, 8'h00, 1, 8'hC0, 1'b0},  // ready change of drive 0
    '{1'b0, OFF_DATA, 8'h00, 1, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, OPC_SEEK, 1, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'h01, 1, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'hFF, 1, 8'h00, 1'b1},  // seek to the top cylinder
    '{1'b1, OFF_DATA, OPC_SENSE_DRIVE, 0, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'h01, 0, 8'h00, 1'b0},
    '{1'b0, OFF_DATA, 8'h00, 1, 8'h20, 1'b0},  // drive 1 away from track zero
    '{1'b1, OFF_DATA, 8'hE6, 0, 8'h00, 1'b0},  // read with all option bits set
    '{1'b1, OFF_DATA, 8'h04, 0, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'hFF, 0, 8'h00, 1'b0},  // top cylinder, which the advance leaves in place
    '{1'b1, OFF_DATA, 8'h01, 0, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'hFF, 0, 8'h00, 1'b0},  // record at the end of track
    '{1'b1, OFF_DATA, 8'h02, 0, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'hFF, 0, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'h1B, 0, 8'h00, 1'b0},
    '{1'b1, OFF_DATA, 8'hFF, 0, 8'h00, 1'b0}
  };

  // Configuration per phase: drive mask and DMA count, extremes included.
  logic [3:0]  phase_mask[5]  = '{4'hF, 4'h0, 4'hA, 4'h5, 4'hF};
  logic [15:0] phase_count[5] = '{16'd511, 16'd0, 16'hFFFF, 16'd1023, 16'd512};

  // Receiver: random stalls, plus one long hold-off on request.
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_off_req && hold_left == 0) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_off_req <= 1'b0;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each reply with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report("unexpected reply", 8'h00, read_data_o);
      end else begin
        bus_reply_t e;
        e = pending_replies.pop_front();
        if (read_data_o !== e.rd) report("read_data", e.rd, read_data_o);
        if (irq_pulse_o !== e.irq) report("irq_pulse", {7'd0, e.irq}, {7'd0, irq_pulse_o});
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int count;
    sh_mask = 4'hF;
    sh_dma_count = 16'd511;
    sh_dor = '0;
    sh_cmd_len = '0;
    sh_cmd_pos = '0;
    sh_res_len = '0;
    sh_res_pos = '0;
    sh_st0 = '0;
    sh_ready_chg = '0;
    for (int i = 0; i < 9; i++) sh_cmd_buf[i] = '0;
    for (int i = 0; i < 7; i++) sh_res_buf[i] = '0;
    for (int i = 0; i < 4; i++) sh_cyl[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset configuration, then read back the read result.
    recv_idle_pct = 30;
    foreach (directed_rows[i])
      offer_access(directed_rows[i].wr, directed_rows[i].off, directed_rows[i].data,
                   directed_rows[i].check, directed_rows[i].rd, directed_rows[i].irq);
    repeat (7) offer_access(1'b0, OFF_DATA, 8'h00);
    settle();

    // Random phases, each under its own configuration; only the first two idle either side.
    for (int p = 0; p < 5; p++) begin
      write_config(CFG_DRIVE_MASK, {12'd0, phase_mask[p]});
      write_config(CFG_DMA_COUNT, phase_count[p]);
      cfg_we_i <= 1'b0;
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 59 : 0;
      recv_idle_pct = (p == 0) ? 59 : (p == 1) ? 19 : 0;
      if (p == 2) hold_off_req = 1'b1;
      count = 0;
      while (count < 140) random_traffic(count);
      settle();
    end

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
